// ----- rtl/hlcp_pkg.sv -----
package hlcp_pkg;

  // fixed point format of coordinates and projected results
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;
  // pixel coordinates and frame registers
  localparam int PW         = 13;
  // clip parameter t: unsigned, 1.0 = 2^T_BITS
  localparam int T_BITS     = 30;
  localparam int TW         = T_BITS + 1;
  localparam int NUM_PLANES = 5;

  // shared divider geometry: numerator, divisor and quotient widths
  localparam int NW = 64;
  localparam int DW = CW + 2;
  localparam int QW = 32;

  // register stages of one projection lane
  localparam int PROJ_LAT = QW + 4;

  localparam logic [PW-1:0] FRAME_WIDTH_RST  = PW'(640);
  localparam logic [PW-1:0] FRAME_HEIGHT_RST = PW'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
  } line_in_t;

  typedef struct packed {
    logic                 visible;
    logic [PW-1:0]        a_px;
    logic [PW-1:0]        a_py;
    logic signed [CW-1:0] a_depth;
    logic signed [CW-1:0] a_inv_w;
    logic [PW-1:0]        b_px;
    logic [PW-1:0]        b_py;
    logic signed [CW-1:0] b_depth;
    logic signed [CW-1:0] b_inv_w;
  } line_out_t;

  // one restoring division step as it moves down the cell chain
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          ovf;
  } div_step_t;

  // per plane classification of a segment
  typedef struct packed {
    logic          rej;
    logic          is_entry;
    logic          is_exit;
    logic [CW:0]   mag;
    logic [DW-1:0] den;
  } plane_t;

endpackage

// ----- rtl/hlcp_div_cell.sv -----
module hlcp_div_cell import hlcp_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  div_step_t step_i,
  output div_step_t step_o
);

  logic [DW+1:0] trial;
  logic          take;
  div_step_t     step_d, step_q;

  // bring down the next numerator bit and try the subtraction
  always_comb begin
    trial      = {1'b0, step_i.rem, step_i.lo[QW-1]} - {2'b00, step_i.den};
    take       = ~trial[DW+1];
    step_d     = step_i;
    step_d.rem = take ? trial[DW-1:0] : {step_i.rem[DW-2:0], step_i.lo[QW-1]};
    step_d.lo  = {step_i.lo[QW-2:0], 1'b0};
    step_d.quo = {step_i.quo[QW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

// ----- rtl/hlcp_div.sv -----
module hlcp_div import hlcp_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  logic [NW-QW-1:0] hi;
  div_step_t        head;
  div_step_t        chain [QW];

  // upper numerator bits form the first partial remainder; if they already
  // reach the divisor the quotient does not fit (covers a zero divisor too)
  always_comb begin
    hi       = num_i[NW-1:QW];
    head.rem = DW'(hi);
    head.lo  = num_i[QW-1:0];
    head.den = den_i;
    head.quo = '0;
    head.ovf = DW'(hi) >= den_i;
  end

  // one quotient bit per cell
  for (genvar k = 0; k < QW; k++) begin : g_cell
    if (k == 0) begin : g_first
      hlcp_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en_i),
        .step_i (head),
        .step_o (chain[k])
      );
    end else begin : g_next
      hlcp_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en_i),
        .step_i (chain[k-1]),
        .step_o (chain[k])
      );
    end
  end

  assign quo_o = chain[QW-1].quo;
  assign ovf_o = chain[QW-1].ovf;

endmodule

// ----- rtl/hlcp_proj.sv -----
module hlcp_proj import hlcp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  coord_t             a_i [4],
  input  logic signed [CW:0] d_i [4],
  input  logic [TW-1:0]      t_i,
  input  logic [PW-1:0]      fw_i,
  input  logic [PW-1:0]      fh_i,
  output logic [PW-1:0]      px_o,
  output logic [PW-1:0]      py_o,
  output coord_t             depth_o,
  output coord_t             inv_w_o
);

  localparam int PRW = CW + 1 + TW + 1;
  localparam int MW  = CW + 1 + PW + 1;
  localparam logic signed [CW:0] ONE = {{(CW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam coord_t SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [PRW-1:0] prod_q [4];
  logic signed [PRW-1:0] sh     [4];
  coord_t                a1_q   [4];
  coord_t                p_q    [4];
  logic [CW:0]           mag    [4];
  logic [NW-1:0]         num    [4];
  logic [DW-1:0]         den;
  logic [3:0]            sg, nz;
  logic [3:0]            sg_q   [QW];
  logic [3:0]            nz_q   [QW];
  logic [QW-1:0]         quo    [4];
  logic [3:0]            ovf;
  coord_t                res    [4];
  coord_t                q_q    [4];
  logic signed [MW-1:0]  mx_q, my_q, sx, sy;
  coord_t                dz_q, iw_q;

  function automatic logic [PW-1:0] clamp_pix(input logic signed [MW-1:0] v,
                                               input logic [PW-1:0] hi);
    logic [PW-1:0] r;
    if (v[MW-1]) begin
      r = '0;
    end else if (v > $signed({{(MW-PW){1'b0}}, hi})) begin
      r = hi;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // step along the segment: d * t, then floor and add the base point
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = prod_q[i] >>> T_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= d_i[i] * $signed({1'b0, t_i});
        a1_q[i]   <= a_i[i];
        p_q[i]    <= a1_q[i] + coord_t'(sh[i][CW-1:0]);
      end
    end
  end

  // magnitudes and signs for the x/w, y/w, z/w and 1/w divides
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = p_q[i][CW-1] ? (~{1'b1, p_q[i]}) + (CW+1)'(1) : {1'b0, p_q[i]};
    end
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'(mag[i]) << FRAC_BITS;
      sg[i]  = p_q[i][CW-1] ^ p_q[3][CW-1];
      nz[i]  = p_q[i] == '0;
    end
    num[3] = NW'(1) << (2 * FRAC_BITS);
    sg[3]  = p_q[3][CW-1];
    nz[3]  = 1'b0;
    den    = DW'(mag[3]);
  end

  // signs and zero flags travel beside the divider cells
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sg_q[0] <= sg;
      nz_q[0] <= nz;
      for (int k = 1; k < QW; k++) begin
        sg_q[k] <= sg_q[k-1];
        nz_q[k] <= nz_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    hlcp_div u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i]),
      .ovf_o (ovf[i])
    );
  end

  // sign and saturate the quotients
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (nz_q[QW-1][i]) begin
        res[i] = '0;
      end else if (ovf[i]) begin
        res[i] = sg_q[QW-1][i] ? SAT_MIN : SAT_MAX;
      end else if (!sg_q[QW-1][i]) begin
        res[i] = quo[i][QW-1] ? SAT_MAX : coord_t'(quo[i]);
      end else if (quo[i][QW-1] && |quo[i][QW-2:0]) begin
        res[i] = SAT_MIN;
      end else begin
        res[i] = coord_t'(~quo[i] + QW'(1));
      end
    end
  end

  // viewport scaling
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        q_q[i] <= res[i];
      end
      mx_q <= ($signed({q_q[0][CW-1], q_q[0]}) + ONE) * $signed({1'b0, fw_i});
      my_q <= (ONE - $signed({q_q[1][CW-1], q_q[1]})) * $signed({1'b0, fh_i});
      dz_q <= q_q[2];
      iw_q <= q_q[3];
    end
  end

  // floor to whole pixels and clamp into the frame
  always_comb begin
    sx = mx_q >>> (FRAC_BITS + 1);
    sy = my_q >>> (FRAC_BITS + 1);
  end

  assign px_o    = clamp_pix(sx, fw_i);
  assign py_o    = clamp_pix(sy, fh_i);
  assign depth_o = dz_q;
  assign inv_w_o = iw_q;

endmodule

// ----- rtl/homogeneous_line_clip_project_top.sv -----
// Throughput: one segment per cycle unless stalled; the plane and projection dividers are chains
// of 32 single-bit cells, each cell one register stage, so a new divide starts every cycle.
// Stalls freeze the whole pipeline while the output word waits; the skid register takes one word.
// Reset: asynchronous, active low; clears all valid bits and loads frame width 640, height 480.
// No clearing pass; the block accepts words in the first cycle after reset.
module homogeneous_line_clip_project_top import hlcp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  line_in_t      in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output line_out_t     out_data_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [PW-1:0] cfg_data_i
);

  logic [PW-1:0]      fw_q, fh_q;
  logic               adv, in_acc;
  logic               skid_full_q;
  line_in_t           skid_q;
  logic               s1_vld_q;
  line_in_t           s1_q;
  logic signed [DW-1:0] da [NUM_PLANES];
  logic signed [DW-1:0] db [NUM_PLANES];
  logic [DW-1:0]      nda [NUM_PLANES];
  plane_t             plane [NUM_PLANES];
  logic               s2_vld_q;
  line_in_t           s2_item_q;
  plane_t             s2_q [NUM_PLANES];
  logic [NW-1:0]      cnum [NUM_PLANES];
  logic [QW-1:0]      cquo [NUM_PLANES];
  logic [NUM_PLANES-1:0] covf;
  logic [QW-1:0]      side_vld_q;
  line_in_t           side_item_q [QW];
  logic               side_rej_q  [QW];
  logic [NUM_PLANES-1:0] side_ent_q [QW];
  logic [NUM_PLANES-1:0] side_ext_q [QW];
  logic [TW-1:0]      t0, t1;
  logic               vis;
  coord_t             ca [4];
  coord_t             cb [4];
  logic signed [CW:0] cd [4];
  logic               s3_vld_q, s3_vis_q;
  logic [TW-1:0]      s3_t0_q, s3_t1_q;
  coord_t             s3_a_q [4];
  logic signed [CW:0] s3_d_q [4];
  logic [PROJ_LAT-1:0] pv_vld_q, pv_vis_q;
  logic [PW-1:0]      a_px, a_py, b_px, b_py;
  coord_t             a_dz, a_iw, b_dz, b_iw;
  logic               out_valid_q;
  line_out_t          out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being taken
  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~skid_full_q;
  assign in_acc     = in_valid_i & in_ready_o;

  // input skid and first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
      s1_vld_q    <= 1'b0;
    end else if (adv) begin
      skid_full_q <= 1'b0;
      s1_vld_q    <= skid_full_q | in_acc;
    end else if (in_acc) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= skid_full_q ? skid_q : in_data_i;
    end else if (in_acc) begin
      skid_q <= in_data_i;
    end
  end

  // distances of both ends to the five planes
  always_comb begin
    da[0] = DW'(s1_q.a_w);
    da[1] = DW'(s1_q.a_w) - DW'(s1_q.a_x);
    da[2] = DW'(s1_q.a_w) + DW'(s1_q.a_x);
    da[3] = DW'(s1_q.a_w) + DW'(s1_q.a_y);
    da[4] = DW'(s1_q.a_w) - DW'(s1_q.a_y);
    db[0] = DW'(s1_q.b_w);
    db[1] = DW'(s1_q.b_w) - DW'(s1_q.b_x);
    db[2] = DW'(s1_q.b_w) + DW'(s1_q.b_x);
    db[3] = DW'(s1_q.b_w) + DW'(s1_q.b_y);
    db[4] = DW'(s1_q.b_w) - DW'(s1_q.b_y);
    for (int k = 0; k < NUM_PLANES; k++) begin
      nda[k]            = -da[k];
      plane[k].rej      = da[k][DW-1] & db[k][DW-1];
      plane[k].is_entry = da[k][DW-1] & ~db[k][DW-1];
      plane[k].is_exit  = ~da[k][DW-1] & db[k][DW-1];
      plane[k].mag      = da[k][DW-1] ? nda[k][CW:0] : da[k][CW:0];
      plane[k].den      = da[k][DW-1] ? DW'(db[k] - da[k]) : DW'(da[k] - db[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q <= s1_q;
      s2_q      <= plane;
    end
  end

  // crossing parameter: entries rounded up, exits rounded down
  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      cnum[k] = (NW'(s2_q[k].mag) << T_BITS)
              + (s2_q[k].is_entry ? NW'(s2_q[k].den - DW'(1)) : NW'(0));
    end
  end

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_clip
    hlcp_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (cnum[k]),
      .den_i (s2_q[k].den),
      .quo_o (cquo[k]),
      .ovf_o (covf[k])
    );
  end

  // segment data beside the clip dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else if (adv) begin
      side_vld_q <= {side_vld_q[QW-2:0], s2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_item_q[0] <= s2_item_q;
      side_rej_q[0]  <= s2_q[0].rej | s2_q[1].rej | s2_q[2].rej | s2_q[3].rej | s2_q[4].rej;
      for (int k = 0; k < NUM_PLANES; k++) begin
        side_ent_q[0][k] <= s2_q[k].is_entry;
        side_ext_q[0][k] <= s2_q[k].is_exit;
      end
      for (int j = 1; j < QW; j++) begin
        side_item_q[j] <= side_item_q[j-1];
        side_rej_q[j]  <= side_rej_q[j-1];
        side_ent_q[j]  <= side_ent_q[j-1];
        side_ext_q[j]  <= side_ext_q[j-1];
      end
    end
  end

  // narrow [t0,t1] and form the edge vectors
  always_comb begin
    t0 = '0;
    t1 = TW'(1) << T_BITS;
    for (int k = 0; k < NUM_PLANES; k++) begin
      if (side_ent_q[QW-1][k] && cquo[k][TW-1:0] > t0) begin
        t0 = cquo[k][TW-1:0];
      end
      if (side_ext_q[QW-1][k] && cquo[k][TW-1:0] < t1) begin
        t1 = cquo[k][TW-1:0];
      end
    end
    // a quotient overflow means a broken crossing: drop the segment
    vis = ~side_rej_q[QW-1] & ~(t0 > t1)
        & ~|(covf & (side_ent_q[QW-1] | side_ext_q[QW-1]));
    ca[0] = side_item_q[QW-1].a_x;
    ca[1] = side_item_q[QW-1].a_y;
    ca[2] = side_item_q[QW-1].a_z;
    ca[3] = side_item_q[QW-1].a_w;
    cb[0] = side_item_q[QW-1].b_x;
    cb[1] = side_item_q[QW-1].b_y;
    cb[2] = side_item_q[QW-1].b_z;
    cb[3] = side_item_q[QW-1].b_w;
    for (int i = 0; i < 4; i++) begin
      cd[i] = $signed({cb[i][CW-1], cb[i]}) - $signed({ca[i][CW-1], ca[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s3_vis_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= side_vld_q[QW-1];
      s3_vis_q <= vis;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_t0_q <= t0;
      s3_t1_q <= t1;
      s3_a_q  <= ca;
      s3_d_q  <= cd;
    end
  end

  // one projection lane per end
  hlcp_proj u_proj_a (
    .clk_i   (clk_i),
    .en_i    (adv),
    .a_i     (s3_a_q),
    .d_i     (s3_d_q),
    .t_i     (s3_t0_q),
    .fw_i    (fw_q),
    .fh_i    (fh_q),
    .px_o    (a_px),
    .py_o    (a_py),
    .depth_o (a_dz),
    .inv_w_o (a_iw)
  );

  hlcp_proj u_proj_b (
    .clk_i   (clk_i),
    .en_i    (adv),
    .a_i     (s3_a_q),
    .d_i     (s3_d_q),
    .t_i     (s3_t1_q),
    .fw_i    (fw_q),
    .fh_i    (fh_q),
    .px_o    (b_px),
    .py_o    (b_py),
    .depth_o (b_dz),
    .inv_w_o (b_iw)
  );

  // valid and visible flags beside the projection lanes, then the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_vld_q    <= '0;
      pv_vis_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pv_vld_q    <= {pv_vld_q[PROJ_LAT-2:0], s3_vld_q};
      pv_vis_q    <= {pv_vis_q[PROJ_LAT-2:0], s3_vis_q};
      out_valid_q <= pv_vld_q[PROJ_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pv_vis_q[PROJ_LAT-1]) begin
        out_q.visible <= 1'b1;
        out_q.a_px    <= a_px;
        out_q.a_py    <= a_py;
        out_q.a_depth <= a_dz;
        out_q.a_inv_w <= a_iw;
        out_q.b_px    <= b_px;
        out_q.b_py    <= b_py;
        out_q.b_depth <= b_dz;
        out_q.b_inv_w <= b_iw;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a word taken during a stall must land in the skid
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !adv) |=> skid_full_q)
    else $error("stalled input word not held in skid");

  // a rejected segment carries an all-zero word
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.visible) |->
      (out_q.a_px == '0 && out_q.b_px == '0 && out_q.a_py == '0 && out_q.b_py == '0
       && out_q.a_inv_w == '0 && out_q.b_inv_w == '0 && out_q.a_depth == '0
       && out_q.b_depth == '0))
    else $error("rejected segment with nonzero fields");

  // visible pixels stay inside the frame
  a_pix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.visible) |->
      (out_q.a_px <= fw_q && out_q.b_px <= fw_q && out_q.a_py <= fh_q && out_q.b_py <= fh_q))
    else $error("pixel coordinate outside frame");

endmodule

// ----- tb/sv/tb_homogeneous_line_clip_project_checker.sv -----
module tb_homogeneous_line_clip_project_checker import hlcp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  line_in_t      in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  line_out_t     out_data_i,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [PW-1:0] cfg_data_i,
  output int            fail_cnt_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PW-1:0] frame_w;
  logic [PW-1:0] frame_h;
  line_out_t     expected_q[$];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_quot(longint num, longint den);
    longint q;
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    q = num / den;
    if (q > 64'sd2147483647) return 64'sd2147483647;
    if (q < -64'sd2147483648) return -64'sd2147483648;
    return q;
  endfunction

  function automatic longint clamp_pix(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // project one clipped end at parameter t
  function automatic void project_end(longint a[4], longint b[4], longint t,
                                      output logic [PW-1:0] px, output logic [PW-1:0] py,
                                      output logic [CW-1:0] dep, output logic [CW-1:0] inv);
    longint p[4];
    longint one, fw, fh, nx, ny, nz, iw;
    one = longint'(1) << FRAC_BITS;
    fw = frame_w;
    fh = frame_h;
    for (int i = 0; i < 4; i++) p[i] = a[i] + floor_sh((b[i] - a[i]) * t, T_BITS);
    nx = sat_quot(p[0] * one, p[3]);
    ny = sat_quot(p[1] * one, p[3]);
    nz = sat_quot(p[2] * one, p[3]);
    iw = sat_quot(one * one, p[3]);
    px = PW'(clamp_pix(floor_sh((nx + one) * fw, FRAC_BITS + 1), fw));
    py = PW'(clamp_pix(floor_sh((one - ny) * fh, FRAC_BITS + 1), fh));
    dep = CW'(nz);
    inv = CW'(iw);
  endfunction

  function automatic line_out_t clip_line(line_in_t w);
    longint a[4], b[4];
    longint t0, t1, da, db, tt;
    longint cx[NUM_PLANES], cy[NUM_PLANES];
    bit ok;
    line_out_t r;
    cx = '{0, -1, 1, 0, 0};
    cy = '{0, 0, 0, 1, -1};
    a = '{w.a_x, w.a_y, w.a_z, w.a_w};
    b = '{w.b_x, w.b_y, w.b_z, w.b_w};
    r = '0;
    t0 = 0;
    t1 = longint'(1) << T_BITS;
    ok = 1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      da = cx[i] * a[0] + cy[i] * a[1] + a[3];
      db = cx[i] * b[0] + cy[i] * b[1] + b[3];
      if (da < 0 && db < 0) begin
        ok = 0;
        break;
      end
      if (da < 0) begin
        tt = ((-da << T_BITS) + (db - da) - 1) / (db - da);
        if (tt > t0) t0 = tt;
      end else if (db < 0) begin
        tt = (da << T_BITS) / (da - db);
        if (tt < t1) t1 = tt;
      end
    end
    if (!ok || t0 > t1) return r;
    r.visible = 1'b1;
    project_end(a, b, t0, r.a_px, r.a_py, r.a_depth, r.a_inv_w);
    project_end(a, b, t1, r.b_px, r.b_py, r.b_depth, r.b_inv_w);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // register shadow, prediction and comparison
  always_ff @(posedge clk_i or negedge rst_ni) begin
    line_out_t e;
    if (!rst_ni) begin
      frame_w <= FRAME_WIDTH_RST;
      frame_h <= FRAME_HEIGHT_RST;
      fail_cnt_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == REG_FRAME_WIDTH) frame_w <= cfg_data_i;
        else frame_h <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(clip_line(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", out_data_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data_i) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (e.visible !== out_data_i.visible)
              $error("visible exp %0d got %0d", e.visible, out_data_i.visible);
            if (e.a_px !== out_data_i.a_px)
              $error("a_px exp %0d got %0d", e.a_px, out_data_i.a_px);
            if (e.a_py !== out_data_i.a_py)
              $error("a_py exp %0d got %0d", e.a_py, out_data_i.a_py);
            if (e.a_depth !== out_data_i.a_depth)
              $error("a_depth exp %0d got %0d", e.a_depth, out_data_i.a_depth);
            if (e.a_inv_w !== out_data_i.a_inv_w)
              $error("a_inv_w exp %0d got %0d", e.a_inv_w, out_data_i.a_inv_w);
            if (e.b_px !== out_data_i.b_px)
              $error("b_px exp %0d got %0d", e.b_px, out_data_i.b_px);
            if (e.b_py !== out_data_i.b_py)
              $error("b_py exp %0d got %0d", e.b_py, out_data_i.b_py);
            if (e.b_depth !== out_data_i.b_depth)
              $error("b_depth exp %0d got %0d", e.b_depth, out_data_i.b_depth);
            if (e.b_inv_w !== out_data_i.b_inv_w)
              $error("b_inv_w exp %0d got %0d", e.b_inv_w, out_data_i.b_inv_w);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_homogeneous_line_clip_project_top.sv -----
module tb_homogeneous_line_clip_project_top;
  import hlcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 80;
  localparam int WDOG_MAX  = 20000;
  localparam int ONE       = 1 << FRAC_BITS;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  line_in_t      in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  line_out_t     out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [0:0]    cfg_idx_i = '0;
  logic [PW-1:0] cfg_data_i = '0;
  int            fail_cnt;
  int            pending;
  int            idle_cnt;
  bit            calm;

  always #4 clk_i = ~clk_i;

  homogeneous_line_clip_project_top i_dut (.*);

  tb_homogeneous_line_clip_project_checker i_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver stalls, none while calm
  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // valid drops only while idling, so back to back words keep it high
  task automatic send_line(line_in_t w);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_frame(cfg_reg_e idx, logic [PW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic line_in_t mk(int ax, int ay, int az, int aw,
                                  int bx, int by, int bz, int bw);
    line_in_t w;
    w = '{ax, ay, az, aw, bx, by, bz, bw};
    return w;
  endfunction

  // coordinate near the view volume so clipping does real work
  function automatic int near_coord(int w);
    int m;
    m = (w < 0 ? -w : w) + 1;
    if (m > 32'h3fffffff) m = 32'h3fffffff;
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic line_in_t rand_line();
    line_in_t w;
    int aw, bw, sel;
    sel = $urandom_range(9);
    if (sel < 2) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      aw = (sel < 4) ? int'($urandom) : int'($urandom_range(40 * ONE)) - 4 * ONE;
      bw = (sel < 4) ? int'($urandom) : int'($urandom_range(40 * ONE)) - 4 * ONE;
      if (sel == 9) aw = 0;
      w = mk(near_coord(aw), near_coord(aw), int'($urandom), aw,
             near_coord(bw), near_coord(bw), int'($urandom), bw);
    end
    return w;
  endfunction

  initial begin
    int sizes[6];
    sizes = '{4096, 1, 0, 8191, 640, 1000};
    calm = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: inside, outside each plane, crossings, grazing, w zero, extremes
    send_line(mk(0, 0, 0, ONE, ONE / 2, -ONE / 2, ONE, ONE));
    send_line(mk(-ONE, -ONE, 0, ONE, ONE, ONE, 0, ONE));
    send_line(mk(0, 0, 0, -ONE, ONE, 0, 0, -ONE));
    send_line(mk(2 * ONE, 0, 0, ONE, 3 * ONE, 0, 0, ONE));
    send_line(mk(-2 * ONE, 0, 0, ONE, -3 * ONE, 0, 0, ONE));
    send_line(mk(0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0, ONE));
    send_line(mk(0, -2 * ONE, 0, ONE, 0, -3 * ONE, 0, ONE));
    send_line(mk(-3 * ONE, 0, 0, ONE, 3 * ONE, 0, 0, ONE));
    send_line(mk(0, -3 * ONE, ONE, ONE, 0, 3 * ONE, -ONE, ONE));
    send_line(mk(0, 0, ONE, -ONE, 0, 0, ONE, ONE));
    send_line(mk(2 * ONE, 0, 0, ONE, 0, 2 * ONE, 0, ONE));
    send_line(mk(ONE, ONE, 0, ONE, 2 * ONE, 0, 0, ONE));
    send_line(mk(0, 0, ONE, 0, 0, 0, -ONE, 0));
    send_line(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_line(mk(1, 0, 0, 1, -1, 0, 0, 1));
    send_line(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send_line(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_line(mk(0, 0, 32'h7fffffff, 1, 0, 0, 32'h80000000, 1));
    send_line(mk(-1, -1, -1, 32'h7fffffff, 0, 0, 0, 32'h7fffffff));
    send_line(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    drain();

    // random phases across frame sizes, one calm stretch
    for (int ph = 0; ph < 6; ph++) begin
      write_frame(REG_FRAME_WIDTH, PW'(sizes[ph]));
      write_frame(REG_FRAME_HEIGHT, PW'(sizes[(ph + 3) % 6]));
      calm = (ph == 2);
      for (int n = 0; n < 175; n++) send_line(rand_line());
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
